@@ rtl/core/fqrk_pkg.sv @@
// Package for the keyed FIFO queue: sizes, request codes and controller states.
// Depends on nothing; the interfaces and the top level import it.
`default_nettype none

package fqrk_pkg;

  // Storage sizes.
  localparam int CAPACITY = 16;
  localparam int ID_W     = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths of the request and response items.
  localparam int REQ_W = 2;
  localparam int KEY_W = 32;

  // Request codes carried in req_type; the fourth code is ignored.
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_POP    = 2'd2
  } req_code_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP_WAIT,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Circular pointer step forwards.
  function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

  // Circular pointer step backwards.
  function automatic logic [IDX_W-1:0] ptr_dec(input logic [IDX_W-1:0] p);
    return (p == '0) ? IDX_W'(CAPACITY - 1) : p - 1'b1;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/fqrk_if.sv @@
// Handshake interfaces for the request and response channels of the keyed queue.
// Depends on fqrk_pkg for the field widths.
`default_nettype none

interface fqrk_req_if;
  import fqrk_pkg::*;
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [KEY_W-1:0] key_id;

  modport source (output valid, output req_type, output key_id, input ready);
  modport sink   (input valid, input req_type, input key_id, output ready);
endinterface

interface fqrk_rsp_if;
  import fqrk_pkg::*;
  logic             valid;
  logic             ready;
  logic             ok;
  logic [KEY_W-1:0] popped_id;
  logic [CNT_W-1:0] entry_count;

  modport source (output valid, output ok, output popped_id, output entry_count,
                  input ready);
  modport sink   (input valid, input ok, input popped_id, input entry_count,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/fqrk_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read.
// Stand-alone; the contents are undefined until written.
`default_nettype none

module fqrk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with a registered read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/fifo_queue_with_remove_by_key.sv @@
// Top level of the keyed FIFO queue: controller, pointers and response register.
// Depends on fqrk_pkg, the interfaces in fqrk_if.sv and the RAM in fqrk_ram.sv.
`default_nettype none

// An ordered queue of up to CAPACITY identifiers held as a circular buffer in one
// RAM with a registered read. A push appends at the tail and a pop returns the head;
// a pop from a non-empty queue passes through a wait state while the head is read
// from the RAM. A remove walks the queue from the head, reading one entry a cycle;
// once the first matching entry is found, each later entry is written back one place
// nearer the head as it arrives, so the gap closes in the same pass. One request is
// handled at a time; a new one is taken as soon as the result of the last sits in
// the response register. Every request gives one result: a success flag, the
// popped identifier (zero unless a pop succeeded) and the entry count afterwards.
// There is no clearing pass after reset; only entries below the count are ever read.

module fifo_queue_with_remove_by_key
  import fqrk_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  fqrk_req_if.sink   req,
  fqrk_rsp_if.source rsp
);

  // Queue pointers and fill count.
  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] count, count_next;

  // Controller state and removal scan registers.
  state_t           state, state_next;
  logic [KEY_W-1:0] key, key_next;
  logic [CNT_W-1:0] rd_idx, rd_idx_next;
  logic [IDX_W-1:0] rd_ptr, rd_ptr_next;
  logic             arr_valid, arr_valid_next;
  logic             arr_last, arr_last_next;
  logic [IDX_W-1:0] arr_ptr, arr_ptr_next;
  logic [IDX_W-1:0] prev_ptr, prev_ptr_next;
  logic             found, found_next;

  // Result waiting to move into the response register.
  logic             res_ok, res_ok_next;
  logic [KEY_W-1:0] res_popped, res_popped_next;

  // Response register.
  logic             out_valid;
  logic             out_ok;
  logic [KEY_W-1:0] out_popped;
  logic [CNT_W-1:0] out_count;
  logic             load_out;

  // RAM port signals.
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ID_W-1:0]  mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [ID_W-1:0]  mem_rdata;

  logic accept;
  logic issue;
  logic hit;

  fqrk_ram #(
    .WIDTH (ID_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;

  // A removal read is issued while entries remain to be fetched.
  assign issue = (rd_idx < count);
  // The entry arriving from the RAM matches the key being removed.
  assign hit   = arr_valid && (mem_rdata == key);

  // State register and the registers that reset clears.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      arr_valid <= 1'b0;
      found     <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      arr_valid <= arr_valid_next;
      found     <= found_next;
    end
  end

  // Payload registers of the controller.
  always_ff @(posedge clk) begin
    key        <= key_next;
    rd_idx     <= rd_idx_next;
    rd_ptr     <= rd_ptr_next;
    arr_last   <= arr_last_next;
    arr_ptr    <= arr_ptr_next;
    prev_ptr   <= prev_ptr_next;
    res_ok     <= res_ok_next;
    res_popped <= res_popped_next;
  end

  // Next state, pointer updates and RAM accesses.
  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    key_next        = key;
    rd_idx_next     = rd_idx;
    rd_ptr_next     = rd_ptr;
    arr_valid_next  = 1'b0;
    arr_last_next   = arr_last;
    arr_ptr_next    = arr_ptr;
    prev_ptr_next   = prev_ptr;
    found_next      = found;
    res_ok_next     = res_ok;
    res_popped_next = res_popped;
    mem_we          = 1'b0;
    mem_waddr       = tail;
    mem_wdata       = req.key_id;
    mem_re          = 1'b0;
    mem_raddr       = head;
    load_out        = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          res_ok_next     = 1'b0;
          res_popped_next = '0;
          key_next        = req.key_id;
          state_next      = ST_FINISH;
          case (req.req_type)
            REQ_PUSH: begin
              if (count != CNT_W'(CAPACITY)) begin
                mem_we      = 1'b1;
                tail_next   = ptr_inc(tail);
                count_next  = count + 1'b1;
                res_ok_next = 1'b1;
              end
            end
            REQ_REMOVE: begin
              if (count != '0) begin
                rd_idx_next = '0;
                rd_ptr_next = head;
                found_next  = 1'b0;
                state_next  = ST_SCAN;
              end
            end
            REQ_POP: begin
              if (count != '0) begin
                mem_re      = 1'b1;
                head_next   = ptr_inc(head);
                count_next  = count - 1'b1;
                res_ok_next = 1'b1;
                state_next  = ST_POP_WAIT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_POP_WAIT: begin
        res_popped_next = mem_rdata;
        state_next      = ST_FINISH;
      end

      ST_SCAN: begin
        // Fetch the next entry in queue order.
        mem_raddr = rd_ptr;
        if (issue) begin
          mem_re         = 1'b1;
          rd_idx_next    = rd_idx + 1'b1;
          rd_ptr_next    = ptr_inc(rd_ptr);
          arr_valid_next = 1'b1;
          arr_ptr_next   = rd_ptr;
          arr_last_next  = (rd_idx == count - 1'b1);
        end
        // Handle the entry that has just arrived: shift it down behind a match.
        if (arr_valid) begin
          prev_ptr_next = arr_ptr;
          if (found) begin
            mem_we    = 1'b1;
            mem_waddr = prev_ptr;
            mem_wdata = mem_rdata;
          end else if (hit) begin
            found_next = 1'b1;
          end
          if (arr_last) begin
            res_ok_next = found || hit;
            if (found || hit) begin
              tail_next  = ptr_dec(tail);
              count_next = count - 1'b1;
            end
            state_next = ST_FINISH;
          end
        end
      end

      ST_FINISH: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Response register: filled from the pending result, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ok     <= res_ok;
      out_popped <= res_popped;
      out_count  <= count;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.ok          = out_ok;
  assign rsp.popped_id   = out_popped;
  assign rsp.entry_count = out_count;

  // The fill count never exceeds the capacity.
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // A read and a write never touch the same entry in one cycle.
  assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write collide on one entry");

  // The RAM is written only by an accepted push or during a removal scan.
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (accept || state == ST_SCAN))
    else $error("unexpected RAM write");

  // A pop from a non-empty queue lowers the count by one.
  assert property (@(posedge clk) disable iff (rst)
    (accept && req.req_type == REQ_POP && count != '0) |=>
      (count == $past(count) - 1'b1))
    else $error("pop did not lower the count");

  // Head and tail differ whenever the queue is neither empty nor full.
  assert property (@(posedge clk) disable iff (rst)
    (count != CNT_W'(CAPACITY) && count != '0) |-> (head != tail))
    else $error("pointers disagree with the count");

endmodule

`default_nettype wire
